/* rtl/core/rrab_pkg.sv */
`timescale 1ns / 1ps

package rrab_pkg;

  localparam int FRAME_WIDTH  = 2048;
  localparam int FRAME_HEIGHT = 2048;

  localparam int COORD_W    = 11;
  localparam int POS_W      = 12;
  localparam int SIZE_W     = 12;
  localparam int RAD_W      = 11;
  localparam int CHAN_W     = 8;
  localparam int COLOR_W    = 24;
  localparam int ALPHA_W    = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int GEO_W      = 15;
  localparam int FRAME_CMP_W = 13;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECT_LEFT     = 3'd0,
    REG_RECT_TOP      = 3'd1,
    REG_RECT_WIDTH    = 3'd2,
    REG_RECT_HEIGHT   = 3'd3,
    REG_CORNER_RADIUS = 3'd4,
    REG_FILL_COLOR    = 3'd5,
    REG_BLEND_ALPHA   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [POS_W-1:0]  left;
    logic [POS_W-1:0]  top;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [RAD_W-1:0]  radius;
  } rrab_geom_t;

endpackage

/* rtl/core/rounded_rect_alpha_blend_unit.sv */
`timescale 1ns / 1ps
// Rounded rectangle alpha fill, one pixel item per clock while out_ready does not stall the output.
// Pipeline: input register, then result register; out_valid rises once the accepted item moves on.
// Throughput: 1 item per cycle unless stalled; ready follows the result register's ready.
// Reset (synchronous, active low): pipeline emptied, geometry and fill color cleared,
// blend alpha set to 256 (opaque).

module rounded_rect_alpha_blend_unit #(
  parameter int FRAME_WIDTH  = rrab_pkg::FRAME_WIDTH,
  parameter int FRAME_HEIGHT = rrab_pkg::FRAME_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               cfg_wr_en,
  input  logic [rrab_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rrab_pkg::CFG_DATA_W-1:0]    cfg_wdata,

  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [rrab_pkg::COORD_W-1:0]       in_pixel_col,
  input  logic [rrab_pkg::COORD_W-1:0]       in_pixel_row,
  input  logic [rrab_pkg::CHAN_W-1:0]        in_dest_red,
  input  logic [rrab_pkg::CHAN_W-1:0]        in_dest_green,
  input  logic [rrab_pkg::CHAN_W-1:0]        in_dest_blue,

  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rrab_pkg::CHAN_W-1:0]        out_red,
  output logic [rrab_pkg::CHAN_W-1:0]        out_green,
  output logic [rrab_pkg::CHAN_W-1:0]        out_blue,
  output logic                               out_covered
);

  localparam int CW = rrab_pkg::CHAN_W;
  localparam int AW = rrab_pkg::ALPHA_W;

  rrab_pkg::rrab_geom_t              geom_r;
  logic [rrab_pkg::COLOR_W-1:0]      fill_color_r;
  logic [AW-1:0]                     blend_alpha_r;
  logic [AW-1:0]                     alpha_eff;

  logic                              s1_valid_r;
  logic [rrab_pkg::COORD_W-1:0]      col_r, row_r;
  logic [CW-1:0]                     dr_r, dg_r, db_r;

  logic                              out_valid_r;
  logic [CW-1:0]                     red_r, green_r, blue_r;
  logic                              covered_r;

  logic                              cov;
  logic [CW-1:0]                     mix_r, mix_g, mix_b;
  logic                              out_adv;
  logic                              s1_adv;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r        <= '0;
      fill_color_r  <= '0;
      blend_alpha_r <= rrab_pkg::ALPHA_ONE;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rrab_pkg::REG_RECT_LEFT:     geom_r.left   <= cfg_wdata[rrab_pkg::POS_W-1:0];
        rrab_pkg::REG_RECT_TOP:      geom_r.top    <= cfg_wdata[rrab_pkg::POS_W-1:0];
        rrab_pkg::REG_RECT_WIDTH:    geom_r.width  <= cfg_wdata[rrab_pkg::SIZE_W-1:0];
        rrab_pkg::REG_RECT_HEIGHT:   geom_r.height <= cfg_wdata[rrab_pkg::SIZE_W-1:0];
        rrab_pkg::REG_CORNER_RADIUS: geom_r.radius <= cfg_wdata[rrab_pkg::RAD_W-1:0];
        rrab_pkg::REG_FILL_COLOR:    fill_color_r  <= cfg_wdata[rrab_pkg::COLOR_W-1:0];
        rrab_pkg::REG_BLEND_ALPHA:   blend_alpha_r <= cfg_wdata[AW-1:0];
        default: ;
      endcase
    end
  end

  assign alpha_eff = (blend_alpha_r > rrab_pkg::ALPHA_ONE) ? rrab_pkg::ALPHA_ONE
                                                           : blend_alpha_r;

  // handshake
  assign out_adv  = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_adv;
  assign in_ready = !s1_valid_r || out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      col_r <= in_pixel_col;
      row_r <= in_pixel_row;
      dr_r  <= in_dest_red;
      dg_r  <= in_dest_green;
      db_r  <= in_dest_blue;
    end
    if (s1_adv) begin
      red_r     <= mix_r;
      green_r   <= mix_g;
      blue_r    <= mix_b;
      covered_r <= cov;
    end
  end

  rrab_cover #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_cover (
    .geom    (geom_r),
    .col     (col_r),
    .row     (row_r),
    .covered (cov)
  );

  rrab_blend u_blend_r (
    .fill   (fill_color_r[3*CW-1:2*CW]),
    .dest   (dr_r),
    .alpha  (alpha_eff),
    .en     (cov),
    .result (mix_r)
  );

  rrab_blend u_blend_g (
    .fill   (fill_color_r[2*CW-1:CW]),
    .dest   (dg_r),
    .alpha  (alpha_eff),
    .en     (cov),
    .result (mix_g)
  );

  rrab_blend u_blend_b (
    .fill   (fill_color_r[CW-1:0]),
    .dest   (db_r),
    .alpha  (alpha_eff),
    .en     (cov),
    .result (mix_b)
  );

  assign out_valid   = out_valid_r;
  assign out_red     = red_r;
  assign out_green   = green_r;
  assign out_blue    = blue_r;
  assign out_covered = covered_r;

endmodule

/* rtl/core/rrab_cover.sv */
`timescale 1ns / 1ps

module rrab_cover #(
  parameter int FRAME_WIDTH  = rrab_pkg::FRAME_WIDTH,
  parameter int FRAME_HEIGHT = rrab_pkg::FRAME_HEIGHT
) (
  input  rrab_pkg::rrab_geom_t             geom,
  input  logic [rrab_pkg::COORD_W-1:0]     col,
  input  logic [rrab_pkg::COORD_W-1:0]     row,
  output logic                             covered
);

  localparam int GW = rrab_pkg::GEO_W;
  localparam int RW = rrab_pkg::RAD_W;
  localparam int FW = rrab_pkg::FRAME_CMP_W;
  localparam logic [FW-1:0] FRAME_W_LIM = FW'(FRAME_WIDTH);
  localparam logic [FW-1:0] FRAME_H_LIM = FW'(FRAME_HEIGHT);

  logic [RW-1:0]        half_w;
  logic [RW-1:0]        half_h;
  logic [RW-1:0]        r;
  logic signed [GW-1:0] col_s, row_s, x_s, y_s, w_s, h_s, r_s;
  logic signed [GW-1:0] x_end, y_end, x_lc, x_rc, y_tc, y_bc;
  logic signed [GW-1:0] cx, cy, dx, dy, dx_m, dy_m;
  logic [RW-1:0]        dx_abs, dy_abs;
  logic [2*RW-1:0]      dx_sq, dy_sq, r_sq;
  logic [2*RW:0]        d_sq;
  logic                 in_frame, in_rect, top, bot, lft, rgt, corner;

  always_comb begin
    half_w = geom.width[rrab_pkg::SIZE_W-1:1];
    half_h = geom.height[rrab_pkg::SIZE_W-1:1];
    r = geom.radius;
    if (r > half_w) begin
      r = half_w;
    end
    if (r > half_h) begin
      r = half_h;
    end

    col_s = GW'(col);
    row_s = GW'(row);
    x_s   = {{(GW-rrab_pkg::POS_W){geom.left[rrab_pkg::POS_W-1]}}, geom.left};
    y_s   = {{(GW-rrab_pkg::POS_W){geom.top[rrab_pkg::POS_W-1]}}, geom.top};
    w_s   = GW'(geom.width);
    h_s   = GW'(geom.height);
    r_s   = GW'(r);

    x_end = x_s + w_s;
    y_end = y_s + h_s;
    x_lc  = x_s + r_s;
    x_rc  = x_end - r_s;
    y_tc  = y_s + r_s;
    y_bc  = y_end - r_s;

    in_frame = (FW'(col) < FRAME_W_LIM) && (FW'(row) < FRAME_H_LIM);
    in_rect  = (col_s >= x_s) && (col_s < x_end) && (row_s >= y_s) && (row_s < y_end);

    top = row_s < y_tc;
    bot = row_s >= y_bc;
    lft = col_s < x_lc;
    rgt = col_s >= x_rc;
    corner = (top || bot) && (lft || rgt);

    cx = lft ? x_lc : x_rc;
    cy = top ? y_tc : y_bc;
    dx = col_s - cx;
    dy = row_s - cy;
    dx_m = dx[GW-1] ? -dx : dx;
    dy_m = dy[GW-1] ? -dy : dy;
    dx_abs = dx_m[RW-1:0];
    dy_abs = dy_m[RW-1:0];

    dx_sq = (2*RW)'(dx_abs) * (2*RW)'(dx_abs);
    dy_sq = (2*RW)'(dy_abs) * (2*RW)'(dy_abs);
    r_sq  = (2*RW)'(r) * (2*RW)'(r);
    d_sq  = (2*RW+1)'(dx_sq) + (2*RW+1)'(dy_sq);

    covered = in_frame && in_rect && (!corner || (d_sq <= (2*RW+1)'(r_sq)));
  end

endmodule

/* rtl/core/rrab_blend.sv */
`timescale 1ns / 1ps

module rrab_blend (
  input  logic [rrab_pkg::CHAN_W-1:0]  fill,
  input  logic [rrab_pkg::CHAN_W-1:0]  dest,
  input  logic [rrab_pkg::ALPHA_W-1:0] alpha,
  input  logic                         en,
  output logic [rrab_pkg::CHAN_W-1:0]  result
);

  localparam int CW = rrab_pkg::CHAN_W;
  localparam int PW = CW + rrab_pkg::ALPHA_W;

  logic [rrab_pkg::ALPHA_W-1:0] inv_alpha;
  logic [PW-1:0]                sum;

  always_comb begin
    inv_alpha = rrab_pkg::ALPHA_ONE - alpha;
    sum = PW'(fill) * PW'(alpha) + PW'(dest) * PW'(inv_alpha);
    result = en ? sum[2*CW-1:CW] : dest;
  end

endmodule
